[rtl/gas_sensor_average_and_linearize_macros.svh]
// assertion macros shared by the checker of the gas sensor averager
// expects signals clk and rst in the scope where a macro is used
`ifndef GAS_SENSOR_AVERAGE_AND_LINEARIZE_MACROS_SVH
`define GAS_SENSOR_AVERAGE_AND_LINEARIZE_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/gsal_pkg.sv]
// types, constants and lookup tables for the gas sensor averager
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package gsal_pkg;

  localparam int ADC_BITS     = 12;
  localparam int CNT_W        = 16;
  localparam int SUM_W        = 22;
  localparam int SPR_W        = 10;
  localparam int PPM_W        = 15;
  localparam int PT_PPM_W     = 7;
  localparam int TABLE_POINTS = 21;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] READ_PERIOD_RST  = 16'd5000;
  localparam logic [CNT_W-1:0] SAMPLE_PERIOD_RST = 16'd33;
  localparam logic [SPR_W-1:0] SPR_RST          = 10'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READING_PERIOD     = 2'd0,
    CFG_SAMPLE_PERIOD      = 2'd1,
    CFG_SAMPLES_PER_READING = 2'd2
  } cfg_idx_t;

  localparam logic [ADC_BITS-1:0] ADC_POINTS [TABLE_POINTS] = '{
    12'd70,  12'd72,  12'd75,  12'd77,  12'd78,  12'd90,  12'd100,
    12'd105, 12'd110, 12'd115, 12'd120, 12'd145, 12'd170, 12'd190,
    12'd215, 12'd235, 12'd250, 12'd290, 12'd330, 12'd370, 12'd400
  };

  localparam logic [PT_PPM_W-1:0] PPM_POINTS [TABLE_POINTS] = '{
    7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,
    7'd7,  7'd8,  7'd9,  7'd10, 7'd20, 7'd30, 7'd40,
    7'd45, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  // one finished reading waiting for the divide
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SPR_W-1:0] divisor;
  } rd_entry_t;

  typedef struct packed {
    logic      valid;
    rd_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SPR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/gsal_front.sv]
// tick front end: config registers, tick counters and sample accumulation
// depends on gsal_pkg; pushes finished readings into gsal_queue
`timescale 1ns / 1ps
`default_nettype none

module gsal_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gsal_pkg::ADC_BITS-1:0]   adc_sample,
  input  logic                            cfg_valid,
  input  logic [gsal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsal_pkg::CNT_W-1:0]      cfg_data,
  input  logic                            q_full,
  output gsal_pkg::q_push_t               push
);
  import gsal_pkg::*;

  logic [CNT_W-1:0] reading_period;
  logic [CNT_W-1:0] sample_period;
  logic [SPR_W-1:0] samples_per_reading;

  logic [CNT_W-1:0] ticks_since_start, ticks_since_start_next;
  logic [CNT_W-1:0] ticks_since_sample, ticks_since_sample_next;
  logic [SUM_W-1:0] sample_sum, sample_sum_next;
  logic [SPR_W-1:0] samples_taken, samples_taken_next;
  logic             reading_active, reading_active_next;

  logic             accept;
  logic             start_rd;
  logic             take;
  logic             done;
  logic [CNT_W-1:0] tss_inc, tsm_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tss_inc = (ticks_since_start == CNT_MAX) ? CNT_MAX : ticks_since_start + 1'b1;
    tsm_inc = (ticks_since_sample == CNT_MAX) ? CNT_MAX : ticks_since_sample + 1'b1;
    start_rd = !reading_active && (tss_inc >= reading_period);

    ticks_since_start_next  = start_rd ? '0 : tss_inc;
    ticks_since_sample_next = start_rd ? '0 : tsm_inc;
    sample_sum_next         = start_rd ? '0 : sample_sum;
    samples_taken_next      = start_rd ? '0 : samples_taken;
    reading_active_next     = reading_active || start_rd;

    take = reading_active_next && (ticks_since_sample_next >= sample_period);
    done = 1'b0;
    if (take) begin
      ticks_since_sample_next = '0;
      sample_sum_next         = sample_sum_next + SUM_W'(adc_sample);
      samples_taken_next      = samples_taken_next + 1'b1;
      done                    = samples_taken_next >= samples_per_reading;
      if (done) begin
        reading_active_next = 1'b0;
      end
    end
  end

  // a zero count divides by one
  always_comb begin
    push.valid         = accept && done;
    push.entry.sum     = sample_sum_next;
    push.entry.divisor = (samples_per_reading == '0) ? SPR_W'(1) : samples_per_reading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_period      <= READ_PERIOD_RST;
      sample_period       <= SAMPLE_PERIOD_RST;
      samples_per_reading <= SPR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_READING_PERIOD:      reading_period      <= cfg_data;
        CFG_SAMPLE_PERIOD:       sample_period       <= cfg_data;
        CFG_SAMPLES_PER_READING: samples_per_reading <= cfg_data[SPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_start  <= '0;
      ticks_since_sample <= '0;
      sample_sum         <= '0;
      samples_taken      <= '0;
      reading_active     <= 1'b0;
    end else if (accept) begin
      ticks_since_start  <= ticks_since_start_next;
      ticks_since_sample <= ticks_since_sample_next;
      sample_sum         <= sample_sum_next;
      samples_taken      <= samples_taken_next;
      reading_active     <= reading_active_next;
    end
  end

endmodule

`default_nettype wire

[rtl/gsal_queue.sv]
// short queue of finished readings between front end and back end
// depends on gsal_pkg
`timescale 1ns / 1ps
`default_nettype none

module gsal_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gsal_pkg::q_push_t     push,
  input  logic                  pop,
  output gsal_pkg::rd_entry_t   head,
  output logic                  full,
  output logic                  empty
);
  import gsal_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  rd_entry_t         slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == CNT_QW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/gsal_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// depends on gsal_pkg; shared by the mean and the interpolation step
`timescale 1ns / 1ps
`default_nettype none

module gsal_div (
  input  logic               clk,
  input  logic               rst,
  input  gsal_pkg::div_req_t req,
  output gsal_pkg::div_rsp_t rsp
);
  import gsal_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [SPR_W-1:0]  rem;
  logic [SPR_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [SPR_W:0]    trial;
  logic [SPR_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? diff[SPR_W-1:0] : trial[SPR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

[rtl/gsal_back.sv]
// back end: mean by division, table lookup and interpolation, output register
// depends on gsal_pkg; drives gsal_div and pops gsal_queue
`timescale 1ns / 1ps
`default_nettype none

module gsal_back (
  input  logic                          clk,
  input  logic                          rst,
  input  gsal_pkg::rd_entry_t           head,
  input  logic                          q_empty,
  output logic                          pop,
  output gsal_pkg::div_req_t            div_req,
  input  gsal_pkg::div_rsp_t            div_rsp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gsal_pkg::ADC_BITS-1:0] average_adc,
  output logic [gsal_pkg::PPM_W-1:0]    ppm_q8
);
  import gsal_pkg::*;

  localparam int PROD_W = ADC_BITS + PT_PPM_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_AVG  = 5'b00010,
    S_LOOK = 5'b00100,
    S_PPM  = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_t;

  back_state_t         state, state_next;
  logic [ADC_BITS-1:0] avg_q;
  logic [PPM_W-1:0]    ppm_r;
  logic [PPM_W-1:0]    base;

  logic [ADC_BITS-1:0] avg_sat;
  logic [IDX_W-1:0]    sel, sel_lo;
  logic [ADC_BITS-1:0] x0, x1, dx;
  logic [PT_PPM_W-1:0] y0, y1, dy;
  logic [PROD_W-1:0]   prod;
  logic                clamp_lo, clamp_hi, flat;
  logic [PPM_W-1:0]    direct_ppm;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  // mean above the converter range saturates
  assign avg_sat = (|div_rsp.quotient[SUM_W-1:ADC_BITS]) ? {ADC_BITS{1'b1}}
                                                         : div_rsp.quotient[ADC_BITS-1:0];

  // first table point at or above the mean
  always_comb begin
    sel = IDX_W'(TABLE_POINTS - 1);
    for (int k = TABLE_POINTS - 1; k >= 1; k--) begin
      if (avg_q <= ADC_POINTS[k]) begin
        sel = IDX_W'(k);
      end
    end
    sel_lo   = sel - 1'b1;
    x0       = ADC_POINTS[sel_lo];
    x1       = ADC_POINTS[sel];
    y0       = PPM_POINTS[sel_lo];
    y1       = PPM_POINTS[sel];
    dx       = x1 - x0;
    dy       = y1 - y0;
    prod     = PROD_W'(avg_q - x0) * PROD_W'(dy);
    clamp_lo = avg_q <= ADC_POINTS[0];
    clamp_hi = avg_q >= ADC_POINTS[TABLE_POINTS-1];
    flat     = (x1 <= x0) || (avg_q < x0);
    priority if (clamp_lo) begin
      direct_ppm = {PPM_POINTS[0], 8'd0};
    end else if (clamp_hi) begin
      direct_ppm = {PPM_POINTS[TABLE_POINTS-1], 8'd0};
    end else begin
      direct_ppm = {y1, 8'd0};
    end
  end

  always_comb begin
    state_next       = state;
    pop              = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = head.sum;
    div_req.divisor  = head.divisor;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop           = 1'b1;
          div_req.start = 1'b1;
          state_next    = S_AVG;
        end
      end
      S_AVG: begin
        if (div_rsp.done) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        // interpolation numerator stays tiny: at most segment width times rise times 256
        div_req.dividend = SUM_W'({prod, 8'd0});
        div_req.divisor  = SPR_W'(dx);
        if (clamp_lo || clamp_hi || flat) begin
          state_next = S_OUT;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_PPM;
        end
      end
      S_PPM: begin
        if (div_rsp.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_AVG && div_rsp.done) begin
      avg_q <= avg_sat;
    end
    if (state == S_LOOK) begin
      base  <= {y0, 8'd0};
      ppm_r <= direct_ppm;
    end
    if (state == S_PPM && div_rsp.done) begin
      ppm_r <= base + div_rsp.quotient[PPM_W-1:0];
    end
    if (state == S_OUT && out_free) begin
      average_adc <= avg_q;
      ppm_q8      <= ppm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/gas_sensor_average_and_linearize.sv]
// channel  | handshake               | payload
// in       | in_valid / in_ready     | adc_sample, one word per millisecond tick
// out      | out_valid / out_ready   | average_adc, ppm_q8
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a tick is taken whenever the reading queue has room
// a finished reading passes through the queue, the mean divide, a lookup state, the slope
//   divide and the output register, all through the one shared divider; the slope divide
//   is skipped when the mean is clamped or the segment is flat
// reset needs no clearing pass
// a stalled output holds the back end, and a full queue then stalls ticks
//
// top level of the gas sensor averager; depends on gsal_pkg, gsal_front,
// gsal_queue, gsal_div and gsal_back
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_average_and_linearize #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gsal_pkg::ADC_BITS-1:0]  adc_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gsal_pkg::ADC_BITS-1:0]  average_adc,
  output logic [gsal_pkg::PPM_W-1:0]     ppm_q8,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gsal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsal_pkg::CNT_W-1:0]     cfg_data
);
  import gsal_pkg::*;

  q_push_t   push;
  rd_entry_t head;
  logic      q_full, q_empty, pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready = 1'b1;

  gsal_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push)
  );

  gsal_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  gsal_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  gsal_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .average_adc (average_adc),
    .ppm_q8      (ppm_q8)
  );

endmodule

`default_nettype wire

[rtl/gsal_checker.sv]
// port-level checks for the gas sensor averager, bound to the top level
// depends on gsal_pkg and gas_sensor_average_and_linearize_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "gas_sensor_average_and_linearize_macros.svh"

module gsal_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gsal_pkg::ADC_BITS-1:0]  average_adc,
  input logic [gsal_pkg::PPM_W-1:0]     ppm_q8
);
  import gsal_pkg::*;

  localparam logic [PPM_W-1:0] PPM_LO = {PPM_POINTS[0], 8'd0};
  localparam logic [PPM_W-1:0] PPM_HI = {PPM_POINTS[TABLE_POINTS-1], 8'd0};

  logic stall;
  logic mean_lo;
  logic mean_hi;

  assign stall   = out_valid && !out_ready;
  assign mean_lo = out_valid && (average_adc <= ADC_POINTS[0]);
  assign mean_hi = out_valid && (average_adc >= ADC_POINTS[TABLE_POINTS-1]);

  // a held word must not change under it
  `ASSERT_NEXT(a_out_hold, stall, out_valid && $stable({average_adc, ppm_q8}), "word moved")

  `ASSERT_IMPL(a_idle_after_reset, $past(rst), !out_valid, "output valid straight after reset")

  // clamped ends of the curve
  `ASSERT_IMPL(a_clamp_low, mean_lo, ppm_q8 == PPM_LO, "low clamp wrong")

  `ASSERT_IMPL(a_clamp_high, mean_hi, ppm_q8 == PPM_HI, "high clamp wrong")

endmodule

bind gas_sensor_average_and_linearize gsal_port_checks u_gsal_port_checks (.*);

`default_nettype wire
